// File: hw/rtl/sut_pkg.sv
// shared constants, codes and types for the sorted unique set table
package sut_pkg;

   localparam int CAPACITY = 8;
   localparam int KEY_W    = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int RSP_POS_W = 6;
   localparam int RSP_CNT_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_PRESENT   = 2'd3;

   // broadcast to every cell
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] cmp_key;
      logic [KEY_W-1:0] alt_key;
   } cell_ctl_type;

   // what a cell shows its neighbours
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             valid;
      logic             lt;
   } nbr_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             valid;
      logic             lt;
      logic             eq;
      logic             eq_alt;
   } cell_out_type;

endpackage

// File: hw/rtl/sut_cell.sv
// one slot of the sorted table: holds a key, compares it and shifts with its neighbours
module sut_cell import sut_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  nbr_type      left,
   input  nbr_type      right,
   output cell_out_type state
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;
   logic             lt;

   assign lt = valid_ff && ($signed(key_ff) < $signed(ctl.cmp_key));

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.insert && !lt) begin
         // the first slot not below the key takes it, the rest move up
         if (left.lt) begin
            key_in   = ctl.cmp_key;
            valid_in = 1'b1;
         end else begin
            key_in   = left.key;
            valid_in = left.valid;
         end
      end else if (ctl.remove && !lt) begin
         key_in   = right.key;
         valid_in = right.valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign state.key    = key_ff;
   assign state.valid  = valid_ff;
   assign state.lt     = lt;
   assign state.eq     = valid_ff && (key_ff == ctl.cmp_key);
   assign state.eq_alt = valid_ff && (key_ff == ctl.alt_key);

endmodule

// File: hw/rtl/sorted_unique_set_table_unit.sv
// top level of the sorted unique set table: request decode, cell chain and result register
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order in a row of
// cells; every cell compares its key with the request key at once and shifts to
// a neighbour to open or close a gap.
// Request channel: a request (req_opcode, req_key, req_new_key) is taken at a
// rising edge where start is high and busy is low.
// Result channel: rsp_status, rsp_position and rsp_count are valid for the one
// cycle in which rsp_strobe is high; the receiver cannot stall them.
// Insert, remove and find run in the cycle of acceptance, their result appears
// in the next cycle, and busy stays low: one request per cycle while no replace holds busy.
// A replace that goes ahead removes the old key in the cycle of acceptance and
// inserts the new key in a second step with busy high; its result is registered
// from that second step. A replace that fails gives its result like the others.
// Reset empties the table (count zero) and drops any result in flight.
module sorted_unique_set_table_unit import sut_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [OP_W-1:0]             req_opcode,
   input  logic signed [KEY_W-1:0]     req_key,
   input  logic signed [KEY_W-1:0]     req_new_key,
   output logic                        rsp_strobe,
   output logic [STAT_W-1:0]           rsp_status,
   output logic [RSP_POS_W-1:0]        rsp_position,
   output logic [RSP_CNT_W-1:0]        rsp_count
);

   logic                  accept;
   logic                  ph2_ff, ph2_in;
   logic [KEY_W-1:0]      nk_ff, nk_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  strobe_ff, strobe_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [POS_W-1:0]      pos_ff, pos_in;

   cell_ctl_type          ctl;
   cell_out_type          cell_out [CAPACITY];
   nbr_type               left_nbr [CAPACITY];
   nbr_type               right_nbr [CAPACITY];
   logic                  any_eq, any_eq_alt;
   logic [CNT_W-1:0]      n_lt;
   logic                  full;

   assign accept = start && !busy;
   assign busy   = ph2_ff;
   assign full   = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            left_nbr[i] = '{key: '0, valid: 1'b0, lt: 1'b1};
         end else begin
            left_nbr[i] = '{key: cell_out[i-1].key, valid: cell_out[i-1].valid,
                            lt: cell_out[i-1].lt};
         end
         if (i == CAPACITY - 1) begin
            right_nbr[i] = '{key: '0, valid: 1'b0, lt: 1'b0};
         end else begin
            right_nbr[i] = '{key: cell_out[i+1].key, valid: cell_out[i+1].valid,
                             lt: cell_out[i+1].lt};
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         sut_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctl   (ctl),
            .left  (left_nbr[g]),
            .right (right_nbr[g]),
            .state (cell_out[g])
         );
      end
   endgenerate

   // flags below the key form a run from slot zero, so its end gives the position
   always_comb begin
      any_eq     = 1'b0;
      any_eq_alt = 1'b0;
      n_lt       = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_eq     = any_eq | cell_out[i].eq;
         any_eq_alt = any_eq_alt | cell_out[i].eq_alt;
         if (cell_out[i].lt && (i == CAPACITY - 1 || !cell_out[(i + 1) % CAPACITY].lt)) begin
            n_lt = n_lt | CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      ctl.insert  = 1'b0;
      ctl.remove  = 1'b0;
      ctl.cmp_key = ph2_ff ? nk_ff : req_key;
      ctl.alt_key = req_new_key;
      ph2_in      = 1'b0;
      nk_in       = nk_ff;
      count_in    = count_ff;
      strobe_in   = 1'b0;
      status_in   = ST_OK;
      pos_in      = '0;
      if (ph2_ff) begin
         // second half of replace: the new key is known to be absent
         ctl.insert = 1'b1;
         count_in   = count_ff + 1'b1;
         strobe_in  = 1'b1;
         pos_in     = n_lt[POS_W-1:0];
      end else if (accept) begin
         strobe_in = 1'b1;
         case (req_opcode)
            OP_INSERT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else if (any_eq) begin
                  status_in = ST_PRESENT;
               end else begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
                  pos_in     = n_lt[POS_W-1:0];
               end
            end
            OP_REMOVE: begin
               if (!any_eq) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
               end
            end
            OP_REPLACE: begin
               if (!any_eq) begin
                  status_in = ST_NOT_FOUND;
               end else if (any_eq_alt) begin
                  status_in = ST_PRESENT;
               end else begin
                  ctl.remove = 1'b1;
                  count_in   = count_ff - 1'b1;
                  nk_in      = req_new_key;
                  ph2_in     = 1'b1;
                  strobe_in  = 1'b0;
               end
            end
            OP_FIND: begin
               if (!any_eq) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  pos_in = n_lt[POS_W-1:0];
               end
            end
            default: begin
               status_in = ST_NOT_FOUND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      nk_ff     <= nk_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      if (reset) begin
         ph2_ff    <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ph2_ff    <= ph2_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = RSP_POS_W'(pos_ff);
   assign rsp_count    = RSP_CNT_W'(count_ff);

   logic [CAPACITY-1:0] valid_vec;
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_vec[i] = cell_out[i].valid;
      end
   end

   a_ph2_from_replace: assert property (@(posedge clock) disable iff (reset)
      ph2_ff |-> $past(accept && req_opcode == OP_REPLACE))
      else $error("second replace cycle without a replace request");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("entry count disagrees with occupied cells");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode != OP_REPLACE) |=> rsp_strobe)
      else $error("request gave no result");

   a_replace_result: assert property (@(posedge clock) disable iff (reset)
      ph2_ff |=> (rsp_strobe && rsp_status == ST_OK))
      else $error("replace insert half gave no ok result");

endmodule

// File: tb/tb_sorted_unique_set_table_unit.sv
// testbench for the sorted unique set table: directed and random requests against a predictor
`timescale 1ns / 1ps

module tb_sorted_unique_set_table_unit;
   import sut_pkg::*;

   localparam int WATCHDOG_LIMIT = 200;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [RSP_POS_W-1:0] position;
      logic [RSP_CNT_W-1:0] count;
   } set_result_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [OP_W-1:0]             req_opcode;
   logic signed [KEY_W-1:0]     req_key;
   logic signed [KEY_W-1:0]     req_new_key;
   logic                        rsp_strobe;
   logic [STAT_W-1:0]           rsp_status;
   logic [RSP_POS_W-1:0]        rsp_position;
   logic [RSP_CNT_W-1:0]        rsp_count;

   // predicted contents of the table
   logic signed [KEY_W-1:0] held_keys [CAPACITY];
   int                      held_count;

   set_result_type          pending_results [$];
   logic signed [KEY_W-1:0] key_pool [16];
   int                      mismatch_count;
   int                      quiet_cycles = 0;
   int                      gap_percent;

   sorted_unique_set_table_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_key      (req_key),
      .req_new_key  (req_new_key),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic int held_index(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < held_count; i++) begin
         if (held_keys[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic int add_sorted(logic signed [KEY_W-1:0] k);
      int slot;
      slot = held_count;
      for (int i = 0; i < held_count; i++) begin
         if (held_keys[i] >= k) begin
            slot = i;
            break;
         end
      end
      for (int i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
      held_keys[slot] = k;
      held_count++;
      return slot;
   endfunction

   function automatic void drop_slot(int slot);
      for (int i = slot + 1; i < held_count; i++) held_keys[i-1] = held_keys[i];
      held_count--;
   endfunction

   function automatic set_result_type apply_request(logic [OP_W-1:0] op,
                                                    logic signed [KEY_W-1:0] k,
                                                    logic signed [KEY_W-1:0] nk);
      set_result_type r;
      int             at;
      r.status   = ST_OK;
      r.position = '0;
      at = held_index(k);
      case (op)
         OP_INSERT: begin
            // fullness wins over presence
            if (held_count >= CAPACITY) r.status = ST_FULL;
            else if (at >= 0) r.status = ST_PRESENT;
            else r.position = RSP_POS_W'(add_sorted(k));
         end
         OP_REMOVE: begin
            if (at < 0) r.status = ST_NOT_FOUND;
            else drop_slot(at);
         end
         OP_REPLACE: begin
            if (at < 0) r.status = ST_NOT_FOUND;
            else if (held_index(nk) >= 0) r.status = ST_PRESENT;
            else begin
               drop_slot(at);
               r.position = RSP_POS_W'(add_sorted(nk));
            end
         end
         default: begin
            if (at < 0) r.status = ST_NOT_FOUND;
            else r.position = RSP_POS_W'(at);
         end
      endcase
      r.count = RSP_CNT_W'(held_count);
      return r;
   endfunction

   // ---------------- driving ----------------

   // entered and left at a falling edge; start stays high on return
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic signed [KEY_W-1:0] k,
                               input logic signed [KEY_W-1:0] nk);
      int gap;
      if (gap_percent > 0 && $urandom_range(99) < gap_percent) begin
         start = 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      start       = 1'b1;
      req_opcode  = op;
      req_key     = k;
      req_new_key = nk;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_request(op, k, nk));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // ---------------- checking ----------------

   always @(posedge clock) begin
      set_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no request waiting (status %0d)",
                                      rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", rsp_status,
                                         want.status));
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position got %0d want %0d", rsp_position,
                                         want.position));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count got %0d want %0d", rsp_count,
                                         want.count));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_strobe)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------- key choice ----------------

   task automatic refresh_pool();
      for (int i = 0; i < 16; i++) begin
         case ($urandom_range(9))
            0: key_pool[i] = KEY_MIN;
            1: key_pool[i] = KEY_MAX;
            2: key_pool[i] = $signed(32'($urandom_range(3))) - 1;
            default: key_pool[i] = $urandom;
         endcase
      end
   endtask

   function automatic logic signed [KEY_W-1:0] pool_key();
      return key_pool[$urandom_range(15)];
   endfunction

   function automatic logic signed [KEY_W-1:0] held_or_pool_key();
      if (held_count == 0 || $urandom_range(9) < 3) return pool_key();
      return held_keys[$urandom_range(held_count - 1)];
   endfunction

   function automatic logic signed [KEY_W-1:0] mixed_key();
      if ($urandom_range(9) < 3) return $urandom;
      return held_or_pool_key();
   endfunction

   // ---------------- tests ----------------

   task automatic test_empty_table();
      send_request(OP_FIND, 32'sd0, 32'sd0);
      send_request(OP_REMOVE, KEY_MIN, KEY_MAX);
      send_request(OP_REPLACE, KEY_MAX, 32'sd0);
   endtask

   task automatic test_fill_to_capacity();
      send_request(OP_INSERT, 32'sd0, 32'sh5555_5555);
      send_request(OP_INSERT, KEY_MAX, 32'sd0);
      send_request(OP_INSERT, KEY_MIN, 32'sd0);
      send_request(OP_INSERT, -32'sd1, 32'sd0);
      send_request(OP_INSERT, 32'sd1, 32'sd0);
      send_request(OP_INSERT, 32'sh5555_5555, 32'sd0);
      send_request(OP_INSERT, 32'shAAAA_AAAA, 32'sd0);
      send_request(OP_INSERT, 32'sh7FFF_FFFE, 32'sd0);
      // full table: a new key and a held key both report full
      send_request(OP_INSERT, 32'sd5, 32'sd0);
      send_request(OP_INSERT, 32'sd0, 32'sd0);
   endtask

   task automatic test_duplicates_and_lookups();
      send_request(OP_REMOVE, 32'sd1, 32'sd0);
      send_request(OP_INSERT, 32'sd0, 32'sd0);
      send_request(OP_FIND, KEY_MIN, 32'sd0);
      send_request(OP_FIND, KEY_MAX, 32'sd0);
      send_request(OP_FIND, 32'sd12345, 32'sd0);
      send_request(OP_REMOVE, 32'sd12345, 32'sd0);
   endtask

   task automatic test_replace_cases();
      send_request(OP_REPLACE, 32'sd0, 32'sd0);
      send_request(OP_REPLACE, -32'sd1, KEY_MAX);
      send_request(OP_REPLACE, 32'sd999, 32'sd3);
      send_request(OP_REPLACE, KEY_MIN, 32'sd2);
      send_request(OP_REPLACE, KEY_MAX, KEY_MIN);
      send_request(OP_FIND, 32'sd2, 32'sd0);
   endtask

   task automatic test_drain_pause();
      send_request(OP_REMOVE, 32'sd2, 32'sd0);
      send_request(OP_REPLACE, 32'sd0, 32'sd7);
      wait_for_drain();
      send_request(OP_FIND, 32'sd7, 32'sd0);
   endtask

   task automatic test_random_traffic(input int n_items, input bit with_gaps);
      int               insert_weight;
      int               r;
      logic [OP_W-1:0]  op;
      logic signed [KEY_W-1:0] k;
      logic signed [KEY_W-1:0] nk;
      for (int n = 0; n < n_items; n++) begin
         // new phase: fresh keys, new mix and, with gaps on, a new idling level
         if (n % 64 == 0) begin
            refresh_pool();
            insert_weight = $urandom_range(15, 70);
            case ($urandom_range(2))
               0: gap_percent = 0;
               1: gap_percent = 10;
               default: gap_percent = 35;
            endcase
            if (!with_gaps) gap_percent = 0;
         end
         r = $urandom_range(99);
         nk = $urandom;
         if (r < insert_weight) begin
            op = OP_INSERT;
            k  = ($urandom_range(9) < 7) ? pool_key() : mixed_key();
         end else begin
            r = $urandom_range(2);
            k = mixed_key();
            if (r == 0) op = OP_REMOVE;
            else if (r == 1) op = OP_FIND;
            else begin
               op = OP_REPLACE;
               case ($urandom_range(9))
                  0, 1: nk = held_or_pool_key();
                  2:    nk = k;
                  3, 4, 5: nk = pool_key();
                  default: nk = $urandom;
               endcase
            end
         end
         send_request(op, k, nk);
      end
   endtask

   // ---------------- sequence ----------------

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_INSERT;
      req_key        = '0;
      req_new_key    = '0;
      held_count     = 0;
      mismatch_count = 0;
      gap_percent    = 0;
      for (int i = 0; i < CAPACITY; i++) held_keys[i] = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_fill_to_capacity();
      test_duplicates_and_lookups();
      test_replace_cases();
      test_drain_pause();
      test_random_traffic(1500, 1'b1);
      test_random_traffic(250, 1'b0);

      wait_for_drain();
      repeat (4) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/sut_pkg.sv
hw/rtl/sut_cell.sv
hw/rtl/sorted_unique_set_table_unit.sv
tb/tb_sorted_unique_set_table_unit.sv
